[sv/rkx_pkg.sv]
package rkx_pkg;

	localparam int KeyLen = 16;
	localparam int PosW   = $clog2(KeyLen);

	typedef logic [7:0]            byte_t;
	typedef logic [PosW-1:0]       pos_t;
	typedef byte_t [KeyLen-1:0]    key_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_DIRECTION = 2'd0,
		REG_KEY_LOW   = 2'd1,
		REG_KEY_HIGH  = 2'd2
	} reg_idx_t;

	// direction codes
	localparam logic DIR_DECRYPT = 1'b0;
	localparam logic DIR_ENCRYPT = 1'b1;

	localparam pos_t  LAST_POS = pos_t'(KeyLen - 1);

	// key update rule selected by the low three plaintext bits
	typedef enum logic [2:0] {
		RULE_0 = 3'd0,
		RULE_1 = 3'd1,
		RULE_2 = 3'd2,
		RULE_3 = 3'd3,
		RULE_4 = 3'd4,
		RULE_5 = 3'd5,
		RULE_6 = 3'd6,
		RULE_7 = 3'd7
	} rule_t;

	localparam byte_t ADD_R0_K4 = 8'd11;
	localparam byte_t ADD_R0_K3 = 8'd2;
	localparam byte_t ADD_R0_K8 = 8'd7;
	localparam byte_t ADD_R4_K0 = 8'h6f;
	localparam byte_t ADD_R4_K3 = 8'h47;
	localparam byte_t ADD_R4_K4 = 8'h11;
	localparam byte_t ADD_R4_K14 = 8'h40;

	// configuration seen by the datapath
	typedef struct packed {
		logic        direction;
		logic [63:0] key_low;
		logic [63:0] key_high;
	} cfg_t;

	// initial key from configuration, byte 0 in the low bits
	function automatic key_t load_key(cfg_t c);
		key_t k;
		for (int i = 0; i < 8; i++) begin
			k[i]     = c.key_low[8*i +: 8];
			k[i + 8] = c.key_high[8*i +: 8];
		end
		return k;
	endfunction

	// in-order byte adds; later adds see earlier results
	function automatic key_t update_key(key_t k_in, byte_t p);
		key_t k;
		k = k_in;
		unique case (rule_t'(p[2:0]))
			RULE_0: begin
				k[0] = k[0] + p;
				k[4] = k[2] + p + ADD_R0_K4;
				k[3] = k[3] + (p + ADD_R0_K3);
				k[8] = k[6] + ADD_R0_K8;
			end
			RULE_1: begin
				k[2]  = k[9] + k[10];
				k[6]  = k[7] + k[15];
				k[8]  = k[8] + k[1];
				k[15] = k[3] + k[5];
			end
			RULE_2: begin
				k[1]  = k[1] + k[2];
				k[5]  = k[5] + k[6];
				k[7]  = k[7] + k[8];
				k[10] = k[10] + k[11];
			end
			RULE_3: begin
				k[9]  = k[1] + k[2];
				k[11] = k[5] + k[6];
				k[12] = k[7] + k[8];
				k[13] = k[10] + k[11];
			end
			RULE_4: begin
				k[0]  = k[1] + ADD_R4_K0;
				k[3]  = k[4] + ADD_R4_K3;
				k[4]  = k[5] + ADD_R4_K4;
				k[14] = k[15] + ADD_R4_K14;
			end
			RULE_5: begin
				k[2] = k[2] + k[10];
				k[4] = k[5] + k[12];
				k[6] = k[8] + k[14];
				k[8] = k[0] + k[11];
			end
			RULE_6: begin
				// rule 6 runs on into the rule 7 adds
				k[9]  = k[1] + k[11];
				k[11] = k[3] + k[13];
				k[13] = k[5] + k[15];
				k[15] = k[7] + k[9];
				k[1]  = k[5] + k[9];
				k[2]  = k[6] + k[10];
				k[3]  = k[7] + k[11];
				k[4]  = k[8] + k[12];
			end
			RULE_7: begin
				k[1] = k[5] + k[9];
				k[2] = k[6] + k[10];
				k[3] = k[7] + k[11];
				k[4] = k[8] + k[12];
			end
			default: begin
				k = k_in;
			end
		endcase
		return k;
	endfunction

endpackage

[sv/rolling_key_xor_byte_cipher.sv]
// Rolling-key XOR byte cipher.
// Input channel: in_valid / in_ready with data_byte and first_of_stream.
// Output channel: out_valid / out_ready with out_byte, one byte per input byte.
// Configuration: cfg_wen, cfg_index, cfg_wdata; index 0 direction (1 encrypt),
// 1 key bytes 0..7, 2 key bytes 8..15. Write only while the block is idle;
// new key values take effect at the next byte flagged first_of_stream.
// Path: an accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle unless out_byte stalls; the key update after
// every 16th byte is done in the same cycle as that byte, so it costs nothing.
// Reset: key all zero, position zero, both pipeline registers empty,
// configuration registers zero (decrypt).
// Stall: while out_byte waits, the input register still takes one byte;
// after that in_ready drops until the receiver takes the result.
module rolling_key_xor_byte_cipher
	import rkx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        first_of_stream,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte
);

	cfg_t  cfg;
	logic  valid_s1;
	byte_t data_s1;
	logic  first_s1;
	logic  valid_s2;
	byte_t out_byte_s2;
	byte_t res;
	logic  advance;

	rkx_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// stage 1 moves forward when the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1  <= data_byte;
			first_s1 <= first_of_stream;
		end
	end

	rkx_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.data    (data_s1),
		.first   (first_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_byte  = out_byte_s2;

endmodule

[sv/rkx_core.sv]
module rkx_core
	import rkx_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  advance,
	input  byte_t data,
	input  logic  first,
	input  cfg_t  cfg,
	output byte_t res
);

	key_t  key_q;
	pos_t  pos_q;
	byte_t prev_q;

	key_t  key_cur;
	pos_t  pos_cur;
	byte_t plain;
	key_t  key_nxt;
	pos_t  pos_nxt;

	// start of stream reloads the key and restarts the position
	always_comb begin
		key_cur = first ? load_key(cfg) : key_q;
		pos_cur = first ? '0 : pos_q;
		res     = data ^ key_cur[pos_cur];
		plain   = (cfg.direction == DIR_ENCRYPT) ? data : res;
		if (pos_cur == LAST_POS) begin
			key_nxt = update_key(key_cur, prev_q);
			pos_nxt = '0;
		end else begin
			key_nxt = key_cur;
			pos_nxt = pos_cur + pos_t'(1);
		end
	end

	// key, position and last plaintext advance once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			pos_q  <= '0;
			prev_q <= '0;
		end else if (advance) begin
			key_q  <= key_nxt;
			pos_q  <= pos_nxt;
			prev_q <= plain;
		end
	end

endmodule

[sv/rkx_cfg_regs.sv]
module rkx_cfg_regs
	import rkx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_DIRECTION: cfg_q.direction <= cfg_wdata[0];
				REG_KEY_LOW:   cfg_q.key_low   <= cfg_wdata;
				REG_KEY_HIGH:  cfg_q.key_high  <= cfg_wdata;
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/rkx_checker.sv]
module rkx_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("stalled result changed");

	// an accepted transaction reaches the output as a valid result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("accepted transaction produced no result");

	// input side only backs up when a result is waiting
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty result register");

endmodule

bind rolling_key_xor_byte_cipher rkx_checker u_rkx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte)
);
